>>> rtl/frame_ring_fifo_assert.svh
// Assertion macros used by the frame ring queue datapath.
`ifndef FRAME_RING_FIFO_ASSERT_SVH
`define FRAME_RING_FIFO_ASSERT_SVH

// cond must never hold at a clock edge outside reset.
`define FRF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("frame ring queue: forbidden condition seen");

// when trig holds, expr must hold in the next cycle.
`define FRF_ASSERT_NEXT(lbl, clk, rst_n, trig, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error("frame ring queue: expected follow-up missing");

`endif

>>> rtl/frf_pkg.sv
// Types and constants of the frame ring queue.
package frf_pkg;

  localparam int LEN_W      = 6;
  localparam int RING_W     = 5;
  localparam int REMOVED_W  = 4;
  localparam int CNT_W      = 8;
  localparam int DONE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [LEN_W-1:0]  FRAME_LIMIT_RST  = 6'd32;
  localparam logic [RING_W-1:0] SLOTS_IN_USE_RST = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_PEEK   = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEK,
    S_DELETE
  } state_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       empty_frame;
    logic [7:0] delete_count;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [7:0]           payload_byte;
    logic [LEN_W-1:0]     frame_length;
    logic [REMOVED_W-1:0] removed;
    logic                 last;
    logic                 queue_empty;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic load_imm;
    logic peek_emit;
    logic del_step;
    logic del_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic imm;
    logic is_peek;
    logic peek_last;
    logic del_stop;
  } dp_status_t;

endpackage

>>> rtl/frf_ctrl.sv
// Sequencer of the frame ring queue: handshakes, item state and datapath commands.
module frf_ctrl import frf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       cfg_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    in_stall  = !((state_r == S_IDLE) && out_free);
    accept    = in_valid && !in_stall;
    // no register write in a cycle that takes an item
    cfg_ready = (state_r == S_IDLE) && !accept;
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          if (status.imm) begin
            cmd.load_imm = 1'b1;
          end else if (status.is_peek) begin
            state_nxt = S_PEEK;
          end else begin
            state_nxt = S_DELETE;
          end
        end
      end
      S_PEEK: begin
        if (out_free) begin
          cmd.peek_emit = 1'b1;
          if (status.peek_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DELETE: begin
        if (!status.del_stop) begin
          cmd.del_step = 1'b1;
        end else if (out_free) begin
          cmd.del_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.load_imm || cmd.peek_emit || cmd.del_emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/frf_datapath.sv
// Datapath of the frame ring queue: pointers, slot memories, config and result register.
`include "frame_ring_fifo_assert.svh"
module frf_datapath import frf_pkg::*; #(
  parameter int SLOT_COUNT      = 16,
  parameter int MAX_FRAME_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output out_item_t             out_item
);

  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BW    = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam int AW    = SW + BW;
  localparam int DEPTH = SLOT_COUNT << BW;
  localparam int CW    = (SW > RING_W) ? SW + 1 : RING_W + 1;
  localparam logic [LEN_W:0]  MAX_B   = (LEN_W + 1)'(MAX_FRAME_BYTES);
  localparam logic [CW-1:0]   SLOTS_C = CW'(SLOT_COUNT);

  logic [7:0]       byte_mem [DEPTH];
  logic [LEN_W-1:0] len_mem  [SLOT_COUNT];

  logic [SW-1:0]         ws_r, rs_r;
  logic [LEN_W-1:0]      bt_r;
  logic                  trunc_r, rej_r;
  logic [LEN_W-1:0]      fl_r;
  logic [RING_W-1:0]     sui_r;
  logic [LEN_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [DONE_W-1:0]     done_r;
  logic [LEN_W-1:0]      len_q;
  logic [7:0]            rd_q;
  out_item_t             out_r;

  logic [LEN_W-1:0]  eff_limit;
  logic [CW-1:0]     eff_ring;
  logic              empty;
  logic              is_push;
  logic              full_start, rej_now, store, room, wr_byte, trunc_new, close;
  logic [LEN_W-1:0]  bt_inc;
  logic [SW-1:0]     ws_next, ws_new, rs_next;
  logic [AW-1:0]     wr_addr, rd_addr;
  out_item_t         push_res, imm_res, peek_res, del_res;

  function automatic logic [SW-1:0] next_ptr(input logic [SW-1:0] p,
                                             input logic [CW-1:0] ring);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    return (n >= ring) ? '0 : n[SW-1:0];
  endfunction

  always_comb begin
    if (fl_r == '0) begin
      eff_limit = LEN_W'(1);
    end else if ({1'b0, fl_r} > MAX_B) begin
      eff_limit = MAX_B[LEN_W-1:0];
    end else begin
      eff_limit = fl_r;
    end
    if (sui_r < RING_W'(2)) begin
      eff_ring = CW'(2);
    end else if (CW'(sui_r) > SLOTS_C) begin
      eff_ring = SLOTS_C;
    end else begin
      eff_ring = CW'(sui_r);
    end
  end

  always_comb begin
    empty      = (rs_r == ws_r);
    is_push    = (in_item.operation == OP_PUSH);
    ws_next    = next_ptr(ws_r, eff_ring);
    rs_next    = next_ptr(rs_r, eff_ring);
    full_start = (bt_r == '0) && !rej_r && (ws_next == rs_r);
    rej_now    = rej_r || full_start;
    store      = !rej_now && !(in_item.frame_end && in_item.empty_frame);
    room       = (bt_r < eff_limit);
    wr_byte    = store && room;
    bt_inc     = bt_r + LEN_W'(wr_byte);
    trunc_new  = trunc_r || (store && !room);
    close      = !rej_now && in_item.frame_end;
    ws_new     = close ? ws_next : ws_r;
    wr_addr    = {ws_r, bt_r[BW-1:0]};

    push_res = '0;
    push_res.last = 1'b1;
    if (rej_now) begin
      push_res.status      = ST_FULL;
      push_res.queue_empty = empty;
    end else begin
      push_res.status       = trunc_new ? ST_TRUNC : ST_OK;
      push_res.frame_length = bt_inc;
      push_res.queue_empty  = (rs_r == ws_new);
    end

    imm_res = '0;
    imm_res.last        = 1'b1;
    imm_res.queue_empty = empty;
    case (in_item.operation)
      OP_PUSH:   imm_res = push_res;
      OP_PEEK:   imm_res.status = ST_EMPTY;
      OP_DELETE: imm_res.status = empty ? ST_EMPTY : ST_OK;
      default:   imm_res.status = ST_OK;
    endcase

    status.imm = (in_item.operation == OP_PUSH) || (in_item.operation == OP_NONE)
               || ((in_item.operation == OP_PEEK) && empty)
               || ((in_item.operation == OP_DELETE)
                   && (empty || (in_item.delete_count == '0)));
    status.is_peek   = (in_item.operation == OP_PEEK);
    status.peek_last = (len_q == '0) || ((idx_r + LEN_W'(1)) == len_q);
    status.del_stop  = (cnt_r == '0) || empty;

    peek_res = '0;
    peek_res.status       = ST_OK;
    peek_res.payload_byte = (len_q == '0) ? 8'd0 : rd_q;
    peek_res.frame_length = len_q;
    peek_res.last         = status.peek_last;
    peek_res.queue_empty  = empty;

    del_res = '0;
    del_res.status      = ST_OK;
    del_res.removed     = done_r[REMOVED_W-1:0];
    del_res.last        = 1'b1;
    del_res.queue_empty = empty;

    if (cmd.accept) begin
      idx_nxt = '0;
    end else if (cmd.peek_emit) begin
      idx_nxt = idx_r + LEN_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
    rd_addr = {rs_r, idx_nxt[BW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_push && wr_byte) begin
      byte_mem[wr_addr] <= in_item.data_byte;
    end
    if (cmd.accept && is_push && close) begin
      len_mem[ws_r] <= bt_inc;
    end
    rd_q  <= byte_mem[rd_addr];
    len_q <= len_mem[rs_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      out_r <= imm_res;
    end else if (cmd.peek_emit) begin
      out_r <= peek_res;
    end else if (cmd.del_emit) begin
      out_r <= del_res;
    end
    idx_r <= idx_nxt;
    if (cmd.accept) begin
      cnt_r  <= in_item.delete_count;
      done_r <= '0;
    end else if (cmd.del_step) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= done_r + DONE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r    <= '0;
      rs_r    <= '0;
      bt_r    <= '0;
      trunc_r <= 1'b0;
      rej_r   <= 1'b0;
      fl_r    <= FRAME_LIMIT_RST;
      sui_r   <= SLOTS_IN_USE_RST;
    end else begin
      if (cmd.accept && is_push) begin
        ws_r    <= ws_new;
        bt_r    <= close ? '0 : bt_inc;
        trunc_r <= close ? 1'b0 : trunc_new;
        rej_r   <= rej_now && !in_item.frame_end;
      end
      if (cmd.del_step) begin
        rs_r <= rs_next;
      end
      if (cfg_we && (cfg_index == CFG_FRAME_LIMIT)) begin
        fl_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_SLOTS_IN_USE)) begin
        sui_r   <= cfg_data[RING_W-1:0];
        ws_r    <= '0;
        rs_r    <= '0;
        bt_r    <= '0;
        trunc_r <= 1'b0;
        rej_r   <= 1'b0;
      end
    end
  end

  assign out_item = out_r;

  `FRF_ASSERT_NEVER(a_rej_no_bytes, clk, rst_n, rej_r && (bt_r != '0))
  `FRF_ASSERT_NEVER(a_bt_in_range, clk, rst_n, {1'b0, bt_r} > MAX_B)
  `FRF_ASSERT_NEXT(a_del_moves_rs, clk, rst_n, cmd.del_step, rs_r != $past(rs_r))

endmodule

>>> rtl/frame_ring_fifo.sv
// Top level of the frame ring queue: ring of frame slots with push, peek and delete.
//
//   channel   direction  handshake          payload
//   in_       input      in_valid/in_stall  in_item_t
//   out_      output     out_valid/out_stall out_item_t
//   cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Push, unused operation, peek of an empty queue and a delete that removes
// nothing: one item per cycle while the output is not stalled, the result goes
// to the output register. Peek: one byte per cycle while the output is not
// stalled, from the slot memory's registered read port; a frame of length zero
// gives one result. Delete: one ring step per cycle for each frame removed.
// Reset (rst_n low, synchronous) empties the queue; slot memories are not cleared.
// A stalled result holds the output register and stops further item intake.
module frame_ring_fifo import frf_pkg::*; #(
  parameter int SLOT_COUNT      = 16,
  parameter int MAX_FRAME_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  frf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  frf_datapath #(
    .SLOT_COUNT      (SLOT_COUNT),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule
